>>> sv/assert_macros.svh
// assertion macros shared by the anisotropic neighbour distance rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AND_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define AND_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> sv/and_pkg.sv
// shared types and constants for the anisotropic neighbour distance block
// no dependencies; used by the front, back and top modules of the block
package and_pkg;

	// cube and fixed-point constants
	localparam int unsigned CUBE_SIDE_DEF = 3;
	localparam logic [31:0] MAX_NORM_RST  = 32'd65536;
	localparam logic [23:0] MAX_ALPHA_RST = 24'd72090;
	localparam logic [23:0] ALPHA_ONE     = 24'd65536;
	localparam logic [31:0] DIST_ONE      = 32'd65536;
	localparam logic [31:0] DIST_SAT      = 32'hFFFF_FFFF;
	localparam int unsigned QUEUE_DEPTH   = 4;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MAX_NORM  = 2'd0,
		REG_MAX_ALPHA = 2'd1
	} reg_idx_t;

	// scaled direction of one vector
	typedef struct packed {
		logic signed [29:0] r_x;
		logic signed [29:0] r_y;
		logic signed [29:0] r_z;
		logic [59:0]        w;
		logic               zero;
	} dir_t;

	// one classified vector handed from front to back
	typedef struct packed {
		dir_t        dir;
		logic [23:0] alpha;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [4:0]  slot;
		logic [31:0] distance;
		logic        last;
	} result_t;

endpackage

>>> sv/and_fifo.sv
// small register queue used between the block's parts and at its output
// depends on assert_macros.svh
`include "assert_macros.svh"

module and_fifo #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

	`AND_NEVER(fifo_no_overflow, clk, arst_n, push && full, "push into full queue")
	`AND_NEVER(fifo_full_empty, clk, arst_n, full && empty, "queue full and empty at once")
	`AND_ASSERT(fifo_ptr_match, clk, arst_n, empty |-> (wr_ptr_q == rd_ptr_q), "pointers differ when empty")

endmodule

>>> sv/and_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
// no package dependency; used by front and back parts
module and_div_pipe #(
	parameter int unsigned DW = 32,
	parameter int unsigned NB = 16,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] den,
	input  logic [DW-1:0] rem0,
	input  logic [NB-1:0] num,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NB-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic          vld_q  [NB+1];
	logic [DW-1:0] den_q  [NB+1];
	logic [DW-1:0] rem_q  [NB+1];
	logic [NB-1:0] num_q  [NB+1];
	logic [NB-1:0] quo_q  [NB+1];
	logic [SW-1:0] side_q [NB+1];

	assign vld_q[0]  = in_valid;
	assign den_q[0]  = den;
	assign rem_q[0]  = rem0;
	assign num_q[0]  = num;
	assign quo_q[0]  = '0;
	assign side_q[0] = side_in;

	for (genvar g = 0; g < NB; g++) begin : g_stage
		logic [DW:0] trial, diff;
		logic        ge;

		// one trial subtraction
		assign trial = {rem_q[g], num_q[g][NB-1]};
		assign diff  = trial - {1'b0, den_q[g]};
		assign ge    = (trial >= {1'b0, den_q[g]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[g+1] <= 1'b0;
			else if (en)
				vld_q[g+1] <= vld_q[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[g+1]  <= den_q[g];
				rem_q[g+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				num_q[g+1]  <= num_q[g] << 1;
				quo_q[g+1]  <= {quo_q[g][NB-2:0], ge};
				side_q[g+1] <= side_q[g];
			end
		end
	end

	assign out_valid = vld_q[NB];
	assign quo       = quo_q[NB];
	assign side_out  = side_q[NB];

endmodule

>>> sv/and_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage, with sideband
// no package dependency; used by front and back parts
module and_sqrt_pipe #(
	parameter int unsigned RW = 16,
	parameter int unsigned SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] x,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);
	logic            vld_q  [RW+1];
	logic [2*RW-1:0] x_q    [RW+1];
	logic [RW-1:0]   rem_q  [RW+1];
	logic [RW-1:0]   root_q [RW+1];
	logic [SW-1:0]   side_q [RW+1];

	assign vld_q[0]  = in_valid;
	assign x_q[0]    = x;
	assign rem_q[0]  = '0;
	assign root_q[0] = '0;
	assign side_q[0] = side_in;

	for (genvar g = 0; g < RW; g++) begin : g_stage
		logic [RW+1:0] trial, sub, diff;
		logic          ge;

		// bring down two bits and try the next root bit
		assign trial = {rem_q[g], x_q[g][2*RW-1 -: 2]};
		assign sub   = {root_q[g], 2'b01};
		assign diff  = trial - sub;
		assign ge    = (trial >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[g+1] <= 1'b0;
			else if (en)
				vld_q[g+1] <= vld_q[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[g+1]    <= x_q[g] << 2;
				rem_q[g+1]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
				root_q[g+1] <= {root_q[g][RW-2:0], ge};
				side_q[g+1] <= side_q[g];
			end
		end
	end

	assign out_valid = vld_q[RW];
	assign root      = root_q[RW];
	assign side_out  = side_q[RW];

endmodule

>>> sv/and_front.sv
// front part: takes vectors, finds norm, stretch factor and scaled direction
// depends on and_pkg, and_sqrt_pipe, and_div_pipe, assert_macros.svh
`include "assert_macros.svh"

module and_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [31:0]  vec_x,
	input  logic signed [31:0]  vec_y,
	input  logic signed [31:0]  vec_z,
	input  logic [31:0]         max_norm,
	input  logic [23:0]         max_alpha,
	output logic                q_push,
	output and_pkg::item_t      q_data,
	input  logic                q_full
);
	localparam int unsigned DSW = $bits(and_pkg::dir_t) + 2;

	logic en_f;
	logic v_s4;

	// stage 1: magnitudes and common scaling shift
	logic [31:0] mag_x, mag_y, mag_z, mag_or;
	logic [1:0]  shift;
	logic        v_s1;
	logic [31:0] magx_s1, magy_s1, magz_s1;
	logic [2:0]  neg_s1;
	logic [1:0]  shift_s1;

	assign mag_x  = vec_x[31] ? (~vec_x + 32'd1) : vec_x;
	assign mag_y  = vec_y[31] ? (~vec_y + 32'd1) : vec_y;
	assign mag_z  = vec_z[31] ? (~vec_z + 32'd1) : vec_z;
	assign mag_or = mag_x | mag_y | mag_z;

	always_comb begin
		if (mag_or[31])
			shift = 2'd3;
		else if (mag_or[30])
			shift = 2'd2;
		else if (mag_or[29])
			shift = 2'd1;
		else
			shift = 2'd0;
	end

	assign en_f = !(v_s4 && q_full);
	assign full = !en_f;

	// stage 2: squares of magnitudes, scaled components
	logic               v_s2, zero_s2;
	logic [63:0]        sqx_s2, sqy_s2, sqz_s2;
	logic [28:0]        mx_s2, my_s2, mz_s2;
	logic signed [29:0] rx_s2, ry_s2, rz_s2;
	logic [31:0]        shx, shy, shz;

	assign shx = magx_s1 >> shift_s1;
	assign shy = magy_s1 >> shift_s1;
	assign shz = magz_s1 >> shift_s1;

	// stage 3: squared norm and scaled squares
	logic               v_s3, zero_s3;
	logic [63:0]        normsq_s3;
	logic [57:0]        wx_s3, wy_s3, wz_s3;
	logic signed [29:0] rx_s3, ry_s3, rz_s3;

	// stage 4: stretch factor
	and_pkg::dir_t  dir_s4;
	logic [23:0]    alpha_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en_f) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			magx_s1  <= mag_x;
			magy_s1  <= mag_y;
			magz_s1  <= mag_z;
			neg_s1   <= {vec_x[31], vec_y[31], vec_z[31]};
			shift_s1 <= shift;
			sqx_s2   <= magx_s1 * magx_s1;
			sqy_s2   <= magy_s1 * magy_s1;
			sqz_s2   <= magz_s1 * magz_s1;
			mx_s2    <= shx[28:0];
			my_s2    <= shy[28:0];
			mz_s2    <= shz[28:0];
			rx_s2    <= neg_s1[2] ? -$signed({1'b0, shx[28:0]}) : $signed({1'b0, shx[28:0]});
			ry_s2    <= neg_s1[1] ? -$signed({1'b0, shy[28:0]}) : $signed({1'b0, shy[28:0]});
			rz_s2    <= neg_s1[0] ? -$signed({1'b0, shz[28:0]}) : $signed({1'b0, shz[28:0]});
			zero_s2  <= (magx_s1 == '0) && (magy_s1 == '0) && (magz_s1 == '0);
			normsq_s3 <= sqx_s2 + sqy_s2 + sqz_s2;
			wx_s3    <= mx_s2 * mx_s2;
			wy_s3    <= my_s2 * my_s2;
			wz_s3    <= mz_s2 * mz_s2;
			rx_s3    <= rx_s2;
			ry_s3    <= ry_s2;
			rz_s3    <= rz_s2;
			zero_s3  <= zero_s2;
		end
	end

	// norm by pipelined square root
	and_pkg::dir_t dir_in, dir_sq;
	logic          sq_v;
	logic [31:0]   norm;

	always_comb begin
		dir_in.r_x  = rx_s3;
		dir_in.r_y  = ry_s3;
		dir_in.r_z  = rz_s3;
		dir_in.w    = 60'(wx_s3) + 60'(wy_s3) + 60'(wz_s3);
		dir_in.zero = zero_s3;
	end

	and_sqrt_pipe #(
		.RW (32),
		.SW ($bits(and_pkg::dir_t))
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_f),
		.in_valid  (v_s3),
		.x         (normsq_s3),
		.side_in   (dir_in),
		.out_valid (sq_v),
		.root      (norm),
		.side_out  (dir_sq)
	);

	// norm ratio by pipelined divider
	logic [DSW-1:0] rat_side_in, rat_side_out;
	logic           rat_v;
	logic [15:0]    rat_quo;
	and_pkg::dir_t  dir_rat;
	logic           ge_rat, mn0_rat;

	assign rat_side_in = {dir_sq, (norm >= max_norm), (max_norm == '0)};

	and_div_pipe #(
		.DW (32),
		.NB (16),
		.SW (DSW)
	) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_f),
		.in_valid  (sq_v),
		.den       (max_norm),
		.rem0      (norm),
		.num       ('0),
		.side_in   (rat_side_in),
		.out_valid (rat_v),
		.quo       (rat_quo),
		.side_out  (rat_side_out)
	);

	assign {dir_rat, ge_rat, mn0_rat} = rat_side_out;

	// alpha = 1 + ratio * (max_alpha - 1), floor toward minus infinity
	logic [16:0]        ratio;
	logic signed [24:0] adiff;
	logic signed [42:0] prod, alpha_full;

	assign ratio      = ge_rat ? 17'h10000 : {1'b0, rat_quo};
	assign adiff      = $signed({1'b0, max_alpha}) - $signed(25'(and_pkg::ALPHA_ONE));
	assign prod       = $signed({1'b0, ratio}) * adiff;
	assign alpha_full = $signed(43'(and_pkg::ALPHA_ONE)) + (prod >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en_f)
			v_s4 <= rat_v;
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			dir_s4   <= dir_rat;
			alpha_s4 <= mn0_rat ? and_pkg::ALPHA_ONE : alpha_full[23:0];
		end
	end

	// hand over to the queue
	assign q_push       = v_s4 && !q_full;
	assign q_data.dir   = dir_s4;
	assign q_data.alpha = alpha_s4;

	`AND_NEVER(front_no_push_full, clk, arst_n, q_push && q_full, "push into full queue")
	`AND_ASSERT(front_hold_alpha, clk, arst_n, (v_s4 && q_full) |=> $stable(alpha_s4), "alpha changed while stalled")
	`AND_ASSERT(front_hold_valid, clk, arst_n, (v_s4 && q_full) |=> v_s4, "item lost while stalled")

endmodule

>>> sv/and_back.sv
// back part: walks the 27 neighbour offsets and computes each distance
// depends on and_pkg, and_div_pipe, and_sqrt_pipe, assert_macros.svh
`include "assert_macros.svh"

module and_back #(
	parameter int unsigned CUBE_SIDE = and_pkg::CUBE_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  and_pkg::item_t     q_data,
	output logic               o_push,
	output and_pkg::result_t   o_data,
	input  logic               o_full
);
	localparam int unsigned CW   = $clog2(CUBE_SIDE);
	localparam int unsigned HALF = CUBE_SIDE / 2;
	localparam logic [CW-1:0] LAST_IDX = CW'(CUBE_SIDE - 1);
	localparam logic [CW-1:0] MID_IDX  = CW'(HALF);

	typedef struct packed {
		logic [4:0]  slot;
		logic        last;
		logic        center;
		logic        zero;
		logic [23:0] alpha;
	} tag_t;

	localparam int unsigned TW = $bits(tag_t);

	logic en_b, sq_v;

	// offset walker
	logic [CW-1:0] bx_q, by_q, bz_q;
	logic [4:0]    slot_q;
	logic          issue, last_issue;

	assign last_issue = (bx_q == LAST_IDX) && (by_q == LAST_IDX) && (bz_q == LAST_IDX);
	assign issue      = !q_empty && en_b;
	assign q_pop      = issue && last_issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_q   <= '0;
			by_q   <= '0;
			bz_q   <= '0;
			slot_q <= '0;
		end else if (issue) begin
			if (last_issue) begin
				bx_q   <= '0;
				by_q   <= '0;
				bz_q   <= '0;
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 5'd1;
				if (bz_q != LAST_IDX) begin
					bz_q <= bz_q + 1'b1;
				end else begin
					bz_q <= '0;
					if (by_q != LAST_IDX) begin
						by_q <= by_q + 1'b1;
					end else begin
						by_q <= '0;
						bx_q <= bx_q + 1'b1;
					end
				end
			end
		end
	end

	// projection term for one axis
	function automatic logic signed [31:0] proj(input logic [CW-1:0] b,
	                                            input logic signed [29:0] r);
		logic signed [31:0] res;
		if (b == MID_IDX)
			res = '0;
		else if (b < MID_IDX)
			res = -32'(r);
		else
			res = 32'(r);
		return res;
	endfunction

	// stage 1: dot product and offset length
	logic               v_s1;
	logic signed [31:0] d_s1;
	logic [1:0]         n_s1;
	logic [59:0]        w_s1;
	tag_t               tag_s1;
	logic [1:0]         n_c;

	assign n_c = 2'(bx_q != MID_IDX) + 2'(by_q != MID_IDX) + 2'(bz_q != MID_IDX);

	// stage 2: squared dot product and scaled denominator
	logic        v_s2;
	logic [61:0] a_s2, den_s2;
	tag_t        tag_s2;
	logic [31:0] dabs;

	assign dabs = d_s1[31] ? (~d_s1 + 32'd1) : d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en_b) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			d_s1          <= proj(bx_q, q_data.dir.r_x) + proj(by_q, q_data.dir.r_y)
			                 + proj(bz_q, q_data.dir.r_z);
			n_s1          <= n_c;
			w_s1          <= q_data.dir.w;
			tag_s1.slot   <= slot_q;
			tag_s1.last   <= last_issue;
			tag_s1.center <= (n_c == 2'd0);
			tag_s1.zero   <= q_data.dir.zero;
			tag_s1.alpha  <= q_data.alpha;
			a_s2          <= dabs[30:0] * dabs[30:0];
			tag_s2        <= tag_s1;
			case (n_s1)
				2'd1:    den_s2 <= 62'(w_s1);
				2'd2:    den_s2 <= {1'b0, w_s1, 1'b0};
				default: den_s2 <= 62'(w_s1) + {1'b0, w_s1, 1'b0};
			endcase
		end
	end

	// squared cosine by pipelined divider
	logic          top;
	logic [TW:0]   c_side_in, c_side_out;
	logic          c_v, top_c;
	logic [31:0]   c_quo;
	tag_t          tag_c;

	assign top       = (a_s2 >= den_s2);
	assign c_side_in = {top, tag_s2};

	and_div_pipe #(
		.DW (62),
		.NB (32),
		.SW (TW + 1)
	) u_cos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (v_s2),
		.den       (den_s2),
		.rem0      (top ? 62'd0 : a_s2),
		.num       ('0),
		.side_in   (c_side_in),
		.out_valid (c_v),
		.quo       (c_quo),
		.side_out  (c_side_out)
	);

	assign {top_c, tag_c} = c_side_out;

	// stage 3: stretched across-direction term
	logic        v_s3;
	logic [32:0] c_s3, cm;
	logic [40:0] t1_s3;
	logic [56:0] t1_full;
	tag_t        tag_s3;

	assign cm      = 33'h1_0000_0000 - {top_c, c_quo};
	assign t1_full = tag_c.alpha * cm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en_b)
			v_s3 <= c_v;
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			c_s3   <= {top_c, c_quo};
			t1_s3  <= t1_full[56:16];
			tag_s3 <= tag_c;
		end
	end

	// along-direction term by pipelined divider
	logic [TW+41:0] q_side_in, q_side_out;
	logic           q2_v, c0_q2;
	logic [48:0]    q2_quo;
	logic [40:0]    t1_q2;
	tag_t           tag_q2;

	assign q_side_in = {t1_s3, (c_s3 == '0), tag_s3};

	and_div_pipe #(
		.DW (24),
		.NB (49),
		.SW (TW + 42)
	) u_along (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (v_s3),
		.den       (tag_s3.alpha),
		.rem0      ('0),
		.num       ({c_s3, 16'd0}),
		.side_in   (q_side_in),
		.out_valid (q2_v),
		.quo       (q2_quo),
		.side_out  (q_side_out)
	);

	assign {t1_q2, c0_q2, tag_q2} = q_side_out;

	// distance by pipelined square root
	logic [49:0] s_sum;
	logic [TW:0] r_side_out;
	logic [24:0] root;
	logic        c0_r;
	tag_t        tag_r;

	assign s_sum = 50'(t1_q2) + 50'(q2_quo);

	and_sqrt_pipe #(
		.RW (25),
		.SW (TW + 1)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (q2_v),
		.x         (s_sum),
		.side_in   ({c0_q2, tag_q2}),
		.out_valid (sq_v),
		.root      (root),
		.side_out  (r_side_out)
	);

	assign {c0_r, tag_r} = r_side_out;

	// special cases and result beat
	always_comb begin
		o_data.slot = tag_r.slot;
		o_data.last = tag_r.last;
		if (tag_r.center)
			o_data.distance = '0;
		else if (tag_r.zero)
			o_data.distance = and_pkg::DIST_ONE;
		else if (tag_r.alpha == '0)
			o_data.distance = c0_r ? '0 : and_pkg::DIST_SAT;
		else
			o_data.distance = 32'(root);
	end

	assign en_b   = !(sq_v && o_full);
	assign o_push = sq_v && en_b;

	`AND_NEVER(back_no_push_full, clk, arst_n, o_push && o_full, "result pushed into full queue")
	`AND_ASSERT(back_pop_on_last, clk, arst_n, q_pop |-> (issue && slot_q == 5'(CUBE_SIDE * CUBE_SIDE * CUBE_SIDE - 1)), "item released before its last offset")
	`AND_ASSERT(back_walk_reset, clk, arst_n, q_pop |=> (slot_q == '0), "walker not back at first offset")

endmodule

>>> sv/anisotropic_neighbor_distance.sv
// top level of the anisotropic neighbour distance block
// depends on and_pkg, and_fifo, and_front, and_back
//
// Usage: one 3D vector (signed Q16.16 per component) goes in per push beat
// while full is low. For each vector the block returns 27 result beats, one
// per neighbour offset of the 3x3x3 cube in x-major order, each giving the
// slot index, the anisotropic distance (unsigned Q16.16) and a last flag on
// the 27th beat. Results wait on the output ports while empty is low and
// leave on a pop beat.
// Configuration: cfg_we writes max_norm (index 0) or max_alpha (index 1)
// at once; other indexes are ignored. Write only while the block is idle.
// The back end walks one neighbour offset per cycle through its divider and
// root pipelines while the middle queue holds a vector and its output is not
// stalled; it takes the next vector from the middle queue only after issuing
// the last offset of the current one. A vector passes the front stages, the
// norm root, the ratio divider and the stretch stage into the middle queue.
// Reset clears both queues and all pipeline valids and loads the register
// defaults. When pop stalls, the output queue fills, the back pipeline
// freezes, then the middle queue fills and full rises.

module anisotropic_neighbor_distance #(
	parameter int unsigned CUBE_SIDE = and_pkg::CUBE_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic               pop,
	output logic               empty,
	output logic [4:0]         neighbor_slot,
	output logic [31:0]        aniso_distance,
	output logic               last_slot,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	// configuration registers
	logic [31:0] max_norm_q;
	logic [23:0] max_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_norm_q  <= and_pkg::MAX_NORM_RST;
			max_alpha_q <= and_pkg::MAX_ALPHA_RST;
		end else if (cfg_we) begin
			case (and_pkg::reg_idx_t'(cfg_index))
				and_pkg::REG_MAX_NORM:  max_norm_q  <= cfg_data;
				and_pkg::REG_MAX_ALPHA: max_alpha_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// front part
	logic           mid_push, mid_full, mid_pop, mid_empty;
	and_pkg::item_t mid_in, mid_out;

	and_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.max_norm  (max_norm_q),
		.max_alpha (max_alpha_q),
		.q_push    (mid_push),
		.q_data    (mid_in),
		.q_full    (mid_full)
	);

	// queue between front and back
	and_fifo #(
		.W     ($bits(and_pkg::item_t)),
		.DEPTH (and_pkg::QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	// back part
	logic             res_push, res_full;
	and_pkg::result_t res_in, res_out;

	and_back #(
		.CUBE_SIDE (CUBE_SIDE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (mid_empty),
		.q_pop   (mid_pop),
		.q_data  (mid_out),
		.o_push  (res_push),
		.o_data  (res_in),
		.o_full  (res_full)
	);

	// result queue
	and_fifo #(
		.W     ($bits(and_pkg::result_t)),
		.DEPTH (and_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign neighbor_slot  = res_out.slot;
	assign aniso_distance = res_out.distance;
	assign last_slot      = res_out.last;

endmodule

>>> verif/anisotropic_neighbor_distance_test.sv
// self-checking testbench for anisotropic_neighbor_distance: queue-style driver and monitor
// depends on and_pkg and the anisotropic_neighbor_distance rtl
module anisotropic_neighbor_distance_test;

	localparam logic [1:0] UNUSED_REG_IDX = 2'd2;
	localparam logic [1:0] SPARE_REG_IDX  = 2'd3;
	localparam int         SETTLE_CYCLES  = 200;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         CUBE_POINTS    = 27;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vector_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [31:0] vec_x = '0;
	logic signed [31:0] vec_y = '0;
	logic signed [31:0] vec_z = '0;
	logic               pop = 1'b0;
	logic               empty;
	logic [4:0]         neighbor_slot;
	logic [31:0]        aniso_distance;
	logic               last_slot;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	vector_t            vector_q[$];
	and_pkg::result_t   distance_q[$];
	logic [31:0]        norm_limit = and_pkg::MAX_NORM_RST;
	logic [23:0]        alpha_limit = and_pkg::MAX_ALPHA_RST;
	int                 send_idle = 0;
	int                 recv_idle = 0;
	int                 hold_req = 0;
	int                 hold_left = 0;
	int                 errors = 0;

	anisotropic_neighbor_distance u_dut (.*);

	always #2 clk = ~clk;

	// integer square root, floor
	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// floor(a * 2^32 / b) by restoring division, a <= b
	function automatic logic [63:0] cos_frac(logic [63:0] a, logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		q = 0;
		r = a;
		if (r >= b) begin
			q = 1;
			r -= b;
		end
		for (int i = 0; i < 32; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= b) begin
				r -= b;
				q |= 1;
			end
		end
		return q;
	endfunction

	// stretch factor from the vector norm and the current registers
	function automatic logic [63:0] stretch_of(logic [63:0] norm);
		logic [63:0] ratio;
		longint      prod;
		longint      part;
		if (norm_limit == 0)
			return 64'(and_pkg::ALPHA_ONE);
		if (norm >= 64'(norm_limit))
			ratio = 65536;
		else
			ratio = (norm << 16) / 64'(norm_limit);
		prod = longint'(ratio) * (longint'(alpha_limit) - 65536);
		if (prod >= 0)
			part = prod / 65536;
		else
			part = -((-prod + 65535) / 65536);
		return 64'(65536 + part);
	endfunction

	// expected 27 distance beats for one vector
	function automatic void predict_distances(vector_t v);
		longint           comp[3];
		longint           dirv[3];
		logic [63:0]      mags[3];
		logic [63:0]      normsq;
		logic [63:0]      maxmag;
		logic [63:0]      w;
		logic [63:0]      alpha;
		logic [63:0]      n;
		logic [63:0]      dm;
		logic [63:0]      c;
		logic [63:0]      s;
		logic [63:0]      span;
		longint           d;
		int               sh;
		int               k;
		and_pkg::result_t res;
		comp[0] = v.x;
		comp[1] = v.y;
		comp[2] = v.z;
		normsq = 0;
		maxmag = 0;
		w = 0;
		sh = 0;
		k = 0;
		for (int i = 0; i < 3; i++) begin
			mags[i] = comp[i] < 0 ? 64'(-comp[i]) : 64'(comp[i]);
			normsq += mags[i] * mags[i];
			if (mags[i] > maxmag)
				maxmag = mags[i];
		end
		alpha = stretch_of(int_sqrt(normsq));
		while ((maxmag >> sh) >= (64'd1 << 29))
			sh++;
		for (int i = 0; i < 3; i++) begin
			dirv[i] = comp[i] < 0 ? -longint'(mags[i] >> sh) : longint'(mags[i] >> sh);
			w += (mags[i] >> sh) * (mags[i] >> sh);
		end
		for (int bx = 0; bx < 3; bx++)
			for (int by = 0; by < 3; by++)
				for (int bz = 0; bz < 3; bz++) begin
					n = (bx - 1) * (bx - 1) + (by - 1) * (by - 1) + (bz - 1) * (bz - 1);
					if (n == 0) begin
						span = 0;
					end else if (normsq == 0) begin
						span = 64'(and_pkg::DIST_ONE);
					end else begin
						d = (bx - 1) * dirv[0] + (by - 1) * dirv[1] + (bz - 1) * dirv[2];
						dm = d < 0 ? 64'(-d) : 64'(d);
						c = cos_frac(dm * dm, n * w);
						if (alpha == 0) begin
							span = (c == 0) ? 64'd0 : 64'(and_pkg::DIST_SAT);
						end else begin
							s = ((alpha * ((64'd1 << 32) - c)) >> 16) + (c << 16) / alpha;
							span = int_sqrt(s);
							if (span > 64'(and_pkg::DIST_SAT))
								span = 64'(and_pkg::DIST_SAT);
						end
					end
					res.slot = 5'(bz + 3 * (by + 3 * bx));
					res.distance = span[31:0];
					res.last = (k == CUBE_POINTS - 1);
					distance_q.push_back(res);
					k++;
				end
	endfunction

	// random vector: full range, small, single axis or sparse
	function automatic vector_t random_vector();
		vector_t v;
		int      mode;
		mode = $urandom_range(3);
		v.x = $urandom;
		v.y = $urandom;
		v.z = $urandom;
		case (mode)
			1: begin
				v.x = $signed(v.x) >>> $urandom_range(31);
				v.y = $signed(v.y) >>> $urandom_range(31);
				v.z = $signed(v.z) >>> $urandom_range(31);
			end
			2: begin
				if ($urandom_range(1)) v.x = 0;
				if ($urandom_range(1)) v.y = 0;
				if ($urandom_range(1)) v.z = 0;
			end
			3: begin
				v.x = $signed(v.x) >>> 12;
				v.y = 0;
				v.z = 0;
			end
			default: ;
		endcase
		return v;
	endfunction

	// sender: one vector per push beat, predicted on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_distances('{vec_x, vec_y, vec_z});
				void'(vector_q.pop_front());
			end
			if (push && full) begin
				push <= 1'b1;
			end else if (vector_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				push <= 1'b1;
				vec_x <= vector_q[0].x;
				vec_y <= vector_q[0].y;
				vec_z <= vector_q[0].z;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: check each result beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (distance_q.size() == 0) begin
					$error("unexpected result beat, slot %0d", neighbor_slot);
					errors++;
				end else begin
					if (neighbor_slot !== distance_q[0].slot) begin
						$error("neighbor_slot: expected %0d actual %0d",
							distance_q[0].slot, neighbor_slot);
						errors++;
					end
					if (aniso_distance !== distance_q[0].distance) begin
						$error("aniso_distance: expected %h actual %h",
							distance_q[0].distance, aniso_distance);
						errors++;
					end
					if (last_slot !== distance_q[0].last) begin
						$error("last_slot: expected %0d actual %0d",
							distance_q[0].last, last_slot);
						errors++;
					end
					void'(distance_q.pop_front());
				end
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// register write, only while idle
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == and_pkg::REG_MAX_NORM)
			norm_limit = value;
		else if (idx == and_pkg::REG_MAX_ALPHA)
			alpha_limit = value[23:0];
	endtask

	// run a batch of random vectors and wait until every result is back
	task automatic run_batch(int count);
		for (int i = 0; i < count; i++)
			vector_q.push_back(random_vector());
		drain();
	endtask

	task automatic drain();
		while (vector_q.size() > 0 || push || distance_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		vector_t directed[$];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero vector, extremes, shift boundary, default registers
		send_idle = 31;
		recv_idle = 63;
		directed = '{
			'{32'sd0, 32'sd0, 32'sd0},
			'{32'sd1, 32'sd0, 32'sd0},
			'{32'h7FFF_FFFF, 32'sd0, 32'sd0},
			'{32'h8000_0000, 32'sd0, 32'sd0},
			'{32'sd0, 32'h8000_0000, 32'sd0},
			'{32'sd0, 32'sd0, 32'h7FFF_FFFF},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'sd65536, 32'sd65536, 32'sd65536},
			'{-32'sd65536, 32'sd32768, -32'sd1},
			'{32'sd1, -32'sd1, 32'sd1},
			'{32'h2000_0000, 32'h1FFF_FFFF, -32'sh2000_0000},
			'{32'sd196608, -32'sd262144, 32'sd0},
			'{-32'sd1, -32'sd1, -32'sd1}
		};
		foreach (directed[i])
			vector_q.push_back(directed[i]);
		drain();

		// zero max_norm gives unit stretch; stray indexes are ignored
		write_reg(and_pkg::REG_MAX_NORM, 32'd0);
		write_reg(UNUSED_REG_IDX, 32'hFFFF_FFFF);
		write_reg(SPARE_REG_IDX, 32'h1234_5678);
		run_batch(20);

		// largest registers
		write_reg(and_pkg::REG_MAX_NORM, 32'hFFFF_FFFF);
		write_reg(and_pkg::REG_MAX_ALPHA, 32'h00FF_FFFF);
		run_batch(30);

		send_idle = 63;
		recv_idle = 31;
		// zero stretch at and above max_norm
		write_reg(and_pkg::REG_MAX_NORM, 32'd65536);
		write_reg(and_pkg::REG_MAX_ALPHA, 32'd0);
		vector_q.push_back('{32'sd0, 32'sd0, 32'sd0});
		vector_q.push_back('{32'sd65536, 32'sd0, 32'sd0});
		vector_q.push_back('{32'sd131072, -32'sd131072, 32'sd65536});
		run_batch(27);

		// stretch below one
		write_reg(and_pkg::REG_MAX_ALPHA, 32'd32768);
		write_reg(and_pkg::REG_MAX_NORM, $urandom_range(32'h0100_0000, 1));
		run_batch(30);

		send_idle = 0;
		recv_idle = 0;
		// random registers, back to back; long receiver hold and a large
		// batch on the first so that the block fills and stalls its input
		for (int p = 0; p < 4; p++) begin
			write_reg(and_pkg::REG_MAX_NORM, $urandom >> $urandom_range(31));
			write_reg(and_pkg::REG_MAX_ALPHA, $urandom_range(32'h0003_0000));
			if (p == 0)
				hold_req = HOLD_CYCLES;
			run_batch((p == 0) ? 70 : 12);
		end

		if (errors == 0)
			$display("anisotropic_neighbor_distance regression: pass");
		else
			$display("anisotropic_neighbor_distance regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("anisotropic_neighbor_distance regression: fail");
		$finish;
	end

endmodule
